// File: hdl/spd_pkg.sv
`timescale 1ns / 1ps

package spd_pkg;

  // Price fields are fixed at 32 bits; the half width register at 4 bits.
  localparam int PRICE_W             = 32;
  localparam int HALF_W              = 4;
  localparam int DEF_MAX_HALF_WINDOW = 10;

  localparam logic [HALF_W-1:0] HALF_WINDOW_RST = HALF_W'(5);

  typedef struct packed {
    logic [PRICE_W-1:0] bar_high;
    logic [PRICE_W-1:0] bar_low;
    logic               new_series;
  } spd_in_t;

  typedef struct packed {
    logic               window_full;
    logic               is_swing_high;
    logic               is_swing_low;
    logic [PRICE_W-1:0] swing_high_price;
    logic [PRICE_W-1:0] swing_low_price;
  } spd_out_t;

endpackage

// File: hdl/swing_pivot_detector_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    spd_in_t  (bar_high, bar_low, new_series)
// out_      output     out_valid / out_ready  spd_out_t (window_full, swing flags, prices)
// cfg_      input      cfg_valid / cfg_ready  cfg_half_window, 4 bits
//
// One result per bar, one bar per cycle sustained while out_ready stays high.
// From its input transfer to its result showing on out_, a bar is first shifted
// into the window registers; then the center is compared against the span and
// the result register is loaded. Synchronous active-low reset empties the window count
// and both stages and sets the half width to 5. A stalled out_ holds the result
// register; the window stage takes one more bar, then in_ready stays low until
// out_ready returns, and both stages advance together in that cycle.

module swing_pivot_detector_core import spd_pkg::*; #(
  parameter int MAX_HALF_WINDOW = DEF_MAX_HALF_WINDOW
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  spd_in_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output spd_out_t          out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [HALF_W-1:0] cfg_half_window
);

  localparam int WIN_DEPTH = 2 * MAX_HALF_WINDOW + 1;
  localparam int CNT_W     = $clog2(WIN_DEPTH + 1);

  logic [HALF_W-1:0]  half_window_r;
  logic               stg_valid;
  logic               stg_take;
  logic [PRICE_W-1:0] high_win [WIN_DEPTH];
  logic [PRICE_W-1:0] low_win  [WIN_DEPTH];
  logic [CNT_W-1:0]   bars_seen;

  // Users write configuration only while idle (unenforced); take every transfer at once.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_window_r <= HALF_WINDOW_RST;
    end else if (cfg_valid) begin
      half_window_r <= cfg_half_window;
    end
  end

  // Shift line of the last bars plus the count of bars held.
  spd_window #(
    .MAX_HALF_WINDOW (MAX_HALF_WINDOW)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .stg_valid (stg_valid),
    .stg_take  (stg_take),
    .high_win  (high_win),
    .low_win   (low_win),
    .bars_seen (bars_seen)
  );

  // Parallel compare of the center bar and the result register.
  spd_eval #(
    .MAX_HALF_WINDOW (MAX_HALF_WINDOW)
  ) u_eval (
    .clk         (clk),
    .rst_n       (rst_n),
    .half_window (half_window_r),
    .stg_valid   (stg_valid),
    .stg_take    (stg_take),
    .high_win    (high_win),
    .low_win     (low_win),
    .bars_seen   (bars_seen),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

// File: hdl/spd_window.sv
`timescale 1ns / 1ps

module spd_window import spd_pkg::*; #(
  parameter int MAX_HALF_WINDOW = DEF_MAX_HALF_WINDOW,
  localparam int WIN_DEPTH = 2 * MAX_HALF_WINDOW + 1,
  localparam int CNT_W     = $clog2(WIN_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  spd_in_t            in_data,
  output logic               stg_valid,
  input  logic               stg_take,
  output logic [PRICE_W-1:0] high_win [WIN_DEPTH],
  output logic [PRICE_W-1:0] low_win  [WIN_DEPTH],
  output logic [CNT_W-1:0]   bars_seen
);

  logic               stg_valid_r;
  logic [CNT_W-1:0]   bars_seen_r;
  logic [CNT_W-1:0]   bars_seen_nxt;
  logic [PRICE_W-1:0] high_win_r   [WIN_DEPTH];
  logic [PRICE_W-1:0] low_win_r    [WIN_DEPTH];
  logic [PRICE_W-1:0] high_win_nxt [WIN_DEPTH];
  logic [PRICE_W-1:0] low_win_nxt  [WIN_DEPTH];
  logic               accept;

  // The window may move only when the stage is empty or its bar moves on to evaluation.
  assign in_ready = !stg_valid_r || stg_take;
  assign accept   = in_valid && in_ready;

  always_comb begin
    high_win_nxt[0] = in_data.bar_high;
    low_win_nxt[0]  = in_data.bar_low;
    for (int i = 1; i < WIN_DEPTH; i++) begin
      high_win_nxt[i] = in_data.new_series ? '0 : high_win_r[i-1];
      low_win_nxt[i]  = in_data.new_series ? '0 : low_win_r[i-1];
    end
    if (in_data.new_series) begin
      bars_seen_nxt = CNT_W'(1);
    end else if (bars_seen_r < CNT_W'(WIN_DEPTH)) begin
      bars_seen_nxt = bars_seen_r + CNT_W'(1);
    end else begin
      bars_seen_nxt = bars_seen_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      bars_seen_r <= '0;
    end else begin
      if (accept) begin
        stg_valid_r <= 1'b1;
        bars_seen_r <= bars_seen_nxt;
      end else if (stg_take) begin
        stg_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      high_win_r <= high_win_nxt;
      low_win_r  <= low_win_nxt;
    end
  end

  assign stg_valid = stg_valid_r;
  assign high_win  = high_win_r;
  assign low_win   = low_win_r;
  assign bars_seen = bars_seen_r;

endmodule

// File: hdl/spd_eval.sv
`timescale 1ns / 1ps

module spd_eval import spd_pkg::*; #(
  parameter int MAX_HALF_WINDOW = DEF_MAX_HALF_WINDOW,
  localparam int WIN_DEPTH = 2 * MAX_HALF_WINDOW + 1,
  localparam int CNT_W     = $clog2(WIN_DEPTH + 1),
  localparam int IDX_W     = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [HALF_W-1:0]  half_window,
  input  logic               stg_valid,
  output logic               stg_take,
  input  logic [PRICE_W-1:0] high_win [WIN_DEPTH],
  input  logic [PRICE_W-1:0] low_win  [WIN_DEPTH],
  input  logic [CNT_W-1:0]   bars_seen,
  output logic               out_valid,
  input  logic               out_ready,
  output spd_out_t           out_data
);

  logic               out_valid_r;
  spd_out_t           out_data_r;
  spd_out_t           out_data_nxt;
  logic [IDX_W-1:0]   k_eff;
  logic [CNT_W-1:0]   span;
  logic [PRICE_W-1:0] ctr_high;
  logic [PRICE_W-1:0] ctr_low;
  logic               sh;
  logic               sl;
  logic               full;

  assign stg_take = stg_valid && (!out_valid_r || out_ready);

  // Clamp the half width to 1..MAX_HALF_WINDOW.
  always_comb begin
    if (half_window == '0) begin
      k_eff = IDX_W'(1);
    end else if (32'(half_window) > 32'(MAX_HALF_WINDOW)) begin
      k_eff = IDX_W'(MAX_HALF_WINDOW);
    end else begin
      k_eff = IDX_W'(half_window);
    end
  end

  assign span     = CNT_W'({1'b0, k_eff, 1'b1});
  assign ctr_high = high_win[k_eff];
  assign ctr_low  = low_win[k_eff];
  assign full     = bars_seen >= span;

  // Compare the center against every other bar inside the span in parallel.
  always_comb begin
    sh = 1'b1;
    sl = 1'b1;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      if ((CNT_W'(i) < span) && (IDX_W'(i) != k_eff)) begin
        if (ctr_high < high_win[i]) sh = 1'b0;
        if (ctr_low > low_win[i])   sl = 1'b0;
      end
    end
    out_data_nxt = '0;
    if (full) begin
      out_data_nxt.window_full      = 1'b1;
      out_data_nxt.is_swing_high    = sh;
      out_data_nxt.is_swing_low     = sl;
      out_data_nxt.swing_high_price = ctr_high;
      out_data_nxt.swing_low_price  = ctr_low;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stg_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_take) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
